// ===== rtl/rfd_pkg.sv =====
// shared types, codes and constants of the response frame deframer
`default_nettype none

package rfd_pkg;

    // framing constants
    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [15:0] MIN_LENGTH  = 16'd5;
    localparam logic [15:0] HEADER_TAIL = 16'd4;

    // configuration register indexes
    localparam int unsigned ADDR_W     = 3;
    localparam logic REG_NODE_ID       = 1'b0;
    localparam logic REG_FN_CODE       = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_GOOD    = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_VERSION  = 3'd1;
    localparam logic [2:0] ERR_ZERO_LEN = 3'd2;
    localparam logic [2:0] ERR_SHORT    = 3'd3;
    localparam logic [2:0] ERR_MISMATCH = 3'd4;
    localparam logic [2:0] ERR_DEVICE   = 3'd5;

    // output beat packing
    localparam int unsigned TDATA_W = 32;
    localparam int unsigned TUSER_W = 2;

    // parser phases
    typedef enum logic [3:0] {
        PH_SYNC,
        PH_VER,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_ID,
        PH_FC,
        PH_ERR_LO,
        PH_ERR_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    // expected header values from the register file
    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] fn_code;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic [15:0] device_errors;
        logic        frame_last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/response_frame_deframer_top.sv =====
// top level of the response frame deframer
//
// Takes received serial bytes on the s_ stream, one byte per beat in s_tdata,
// and parses response frames (sync, version, length, server id, function code,
// device error word, payload, two crc bytes). Results leave on the m_ stream:
// m_tuser carries the kind (payload byte, frame good, frame rejected), m_tlast
// marks the result that closes a frame, and m_tdata holds payload byte, error
// code and device error word. Each byte is parsed in the cycle it is taken;
// a result it causes is registered into the output stage in the next cycle. One
// byte is accepted every cycle while s_tready is high.
// A two-entry output register and skid stage let s_tready stay high while
// one result waits; only when both are full does s_tready drop until m_tready
// drains one. The apb port sets the expected server id (address 0) and
// function code (address 4). Synchronous active-low reset returns the parser
// to sync hunting, clears both registers and empties the output stage.
`default_nettype none

module response_frame_deframer_top
    import rfd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input stream: [7:0] rx_byte
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,
    // result stream: [7:0] payload_byte, [10:8] error_code, [26:11] device_errors
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    // [1:0] kind
    output logic [TUSER_W-1:0]      m_tuser,
    output logic                    m_tlast,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t    cfg;
    logic    beat_valid;
    logic    res_valid;
    result_t res;
    logic    space;
    result_t out_data;

    assign s_tready   = space;
    assign beat_valid = s_tvalid && space;

    // configuration registers
    rfd_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame parser
    rfd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (beat_valid),
        .rx_byte    (s_tdata),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // output register and skid
    rfd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (beat_valid && res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    // output beat packing
    assign m_tdata = {5'd0, out_data.device_errors, out_data.error_code,
                      out_data.payload_byte};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.frame_last;

endmodule

`default_nettype wire

// ===== rtl/rfd_regs.sv =====
// apb register file holding the expected server id and function code
`default_nettype none

module rfd_regs
    import rfd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [7:0] node_id_reg;
    logic [7:0] fn_code_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg <= 8'd0;
            fn_code_reg <= 8'd0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_NODE_ID: node_id_reg <= pwdata[7:0];
                REG_FN_CODE: fn_code_reg <= pwdata[7:0];
                default:     node_id_reg <= node_id_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_sel)
            REG_NODE_ID: prdata = {24'd0, node_id_reg};
            REG_FN_CODE: prdata = {24'd0, fn_code_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.node_id = node_id_reg;
    assign cfg.fn_code = fn_code_reg;

endmodule

`default_nettype wire

// ===== rtl/rfd_parser.sv =====
// frame parser state machine, one byte per cycle while beat_valid is high
`default_nettype none

module rfd_parser
    import rfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       beat_valid,
    input  wire logic [7:0] rx_byte,
    input  wire cfg_t       cfg,
    output logic            res_valid,
    output result_t         res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_left_reg, payload_left_next;
    logic [15:0] error_word_reg, error_word_next;
    logic        mismatch_reg, mismatch_next;

    logic [15:0] length_full;
    logic [15:0] error_full;
    logic [15:0] left_dec;

    assign length_full = {rx_byte, frame_length_reg[7:0]};
    assign error_full  = {rx_byte, error_word_reg[7:0]};
    assign left_dec    = (payload_left_reg != 16'd0) ? (payload_left_reg - 16'd1)
                                                     : payload_left_reg;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_SYNC;
            frame_length_reg <= 16'd0;
            payload_left_reg <= 16'd0;
            error_word_reg   <= 16'd0;
            mismatch_reg     <= 1'b0;
        end else if (beat_valid) begin
            phase_reg        <= phase_next;
            frame_length_reg <= frame_length_next;
            payload_left_reg <= payload_left_next;
            error_word_reg   <= error_word_next;
            mismatch_reg     <= mismatch_next;
        end
    end

    // next state
    always_comb begin
        phase_next        = phase_reg;
        frame_length_next = frame_length_reg;
        payload_left_next = payload_left_reg;
        error_word_next   = error_word_reg;
        mismatch_next     = mismatch_reg;
        unique case (phase_reg)
            PH_SYNC: begin
                if (rx_byte == SYNC_BYTE) begin
                    frame_length_next = 16'd0;
                    payload_left_next = 16'd0;
                    error_word_next   = 16'd0;
                    mismatch_next     = 1'b0;
                    phase_next        = PH_VER;
                end
            end
            PH_VER: begin
                phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN_LO : PH_SYNC;
            end
            PH_LEN_LO: begin
                frame_length_next = {8'd0, rx_byte};
                phase_next        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_length_next = length_full;
                phase_next        = (length_full == 16'd0) ? PH_SYNC : PH_ID;
            end
            PH_ID: begin
                if (rx_byte != cfg.node_id) begin
                    mismatch_next = 1'b1;
                end
                phase_next = PH_FC;
            end
            PH_FC: begin
                if (rx_byte != cfg.fn_code) begin
                    mismatch_next = 1'b1;
                end
                phase_next = PH_ERR_LO;
            end
            PH_ERR_LO: begin
                error_word_next = {8'd0, rx_byte};
                phase_next      = PH_ERR_HI;
            end
            PH_ERR_HI: begin
                error_word_next = error_full;
                if (mismatch_reg || (error_full != 16'd0) ||
                    (frame_length_reg < MIN_LENGTH)) begin
                    phase_next = PH_SYNC;
                end else begin
                    payload_left_next = frame_length_reg - HEADER_TAIL;
                    phase_next        = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                payload_left_next = left_dec;
                if (left_dec == 16'd0) begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                phase_next = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                phase_next = PH_SYNC;
            end
            default: begin
                phase_next = PH_SYNC;
            end
        endcase
    end

    // result generation
    always_comb begin
        res_valid = 1'b0;
        res       = '0;
        unique case (phase_reg)
            PH_VER: begin
                if (rx_byte != SYNC_BYTE) begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_REJECT;
                    res.error_code    = ERR_VERSION;
                    res.device_errors = error_word_reg;
                    res.frame_last    = 1'b1;
                end
            end
            PH_LEN_HI: begin
                if (length_full == 16'd0) begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_REJECT;
                    res.error_code    = ERR_ZERO_LEN;
                    res.device_errors = error_word_reg;
                    res.frame_last    = 1'b1;
                end
            end
            PH_ERR_HI: begin
                res.kind          = KIND_REJECT;
                res.device_errors = error_full;
                res.frame_last    = 1'b1;
                priority if (mismatch_reg) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_MISMATCH;
                end else if (error_full != 16'd0) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_DEVICE;
                end else if (frame_length_reg < MIN_LENGTH) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_SHORT;
                end else begin
                    res_valid      = 1'b0;
                    res.error_code = ERR_NONE;
                end
            end
            PH_PAYLOAD: begin
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = rx_byte;
            end
            PH_CRC_HI: begin
                res_valid         = 1'b1;
                res.kind          = KIND_GOOD;
                res.error_code    = ERR_NONE;
                res.device_errors = error_word_reg;
                res.frame_last    = 1'b1;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/rfd_out_buf.sv =====
// output register with a skid stage so the input side waits only when both entries are full
`default_nettype none

module rfd_out_buf
    import rfd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         space,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    main_valid_reg;
    result_t main_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                main_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    // payload moves
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (main_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                main_data_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/response_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the response frame deframer: random frames, predicted result beats
module response_frame_deframer_top_tb;
    import rfd_pkg::*;

    // frame parser prediction and result checking
    class frame_scoreboard;
        result_t     pending_q[$];
        phase_t      phase;
        logic [15:0] frame_len;
        logic [15:0] bytes_left;
        logic [15:0] dev_word;
        bit          id_miss;
        logic [7:0]  want_id;
        logic [7:0]  want_fc;
        int unsigned fails;

        function new();
            phase      = PH_SYNC;
            frame_len  = '0;
            bytes_left = '0;
            dev_word   = '0;
            id_miss    = 1'b0;
            want_id    = '0;
            want_fc    = '0;
            fails      = 0;
        endfunction

        function void set_reg(logic sel, logic [7:0] value);
            if (sel == REG_NODE_ID) begin
                want_id = value;
            end else begin
                want_fc = value;
            end
        endfunction

        // device word is carried on closing beats only
        function void push(logic [1:0] kind, logic [7:0] pbyte, logic [2:0] code, logic last);
            result_t r;
            r.kind          = kind;
            r.payload_byte  = pbyte;
            r.error_code    = code;
            r.device_errors = (kind == KIND_PAYLOAD) ? 16'h0000 : dev_word;
            r.frame_last    = last;
            pending_q.insert(pending_q.size(), r);
        endfunction

        function void reject(logic [2:0] code);
            push(KIND_REJECT, 8'h00, code, 1'b1);
            phase = PH_SYNC;
        endfunction

        // advance the parser by one byte; returns 0 for a byte dropped while hunting
        function bit take_byte(logic [7:0] b);
            case (phase)
                PH_SYNC: begin
                    if (b != SYNC_BYTE) return 1'b0;
                    frame_len  = '0;
                    bytes_left = '0;
                    dev_word   = '0;
                    id_miss    = 1'b0;
                    phase      = PH_VER;
                end
                PH_VER: begin
                    if (b != SYNC_BYTE) reject(ERR_VERSION);
                    else phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len = {8'h00, b};
                    phase     = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    frame_len[15:8] = b;
                    if (frame_len == 16'h0000) reject(ERR_ZERO_LEN);
                    else phase = PH_ID;
                end
                PH_ID: begin
                    if (b != want_id) id_miss = 1'b1;
                    phase = PH_FC;
                end
                PH_FC: begin
                    if (b != want_fc) id_miss = 1'b1;
                    phase = PH_ERR_LO;
                end
                PH_ERR_LO: begin
                    dev_word = {8'h00, b};
                    phase    = PH_ERR_HI;
                end
                // header checks in priority order
                PH_ERR_HI: begin
                    dev_word[15:8] = b;
                    if (id_miss) begin
                        reject(ERR_MISMATCH);
                    end else if (dev_word != 16'h0000) begin
                        reject(ERR_DEVICE);
                    end else if (frame_len < MIN_LENGTH) begin
                        reject(ERR_SHORT);
                    end else begin
                        bytes_left = frame_len - HEADER_TAIL;
                        phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (bytes_left != 16'h0000) bytes_left = bytes_left - 16'd1;
                    if (bytes_left == 16'h0000) phase = PH_CRC_LO;
                    push(KIND_PAYLOAD, b, ERR_NONE, 1'b0);
                end
                PH_CRC_LO: begin
                    phase = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    phase = PH_SYNC;
                    push(KIND_GOOD, 8'h00, ERR_NONE, 1'b1);
                end
                default: begin
                    phase = PH_SYNC;
                end
            endcase
            return 1'b1;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            fails++;
        endtask

        // compare one result beat with the oldest prediction
        task check_beat(logic [TDATA_W-1:0] data, logic [TUSER_W-1:0] user, logic last);
            result_t want;
            if (pending_q.size() == 0) begin
                report($sformatf("unexpected beat kind %0d data %h last %b", user, data, last));
                return;
            end
            want = pending_q.pop_front();
            if (user !== want.kind)
                report($sformatf("kind %0d, want %0d", user, want.kind));
            if (data[7:0] !== want.payload_byte)
                report($sformatf("payload byte %h, want %h", data[7:0], want.payload_byte));
            if (data[10:8] !== want.error_code)
                report($sformatf("error code %0d, want %0d", data[10:8], want.error_code));
            if (data[26:11] !== want.device_errors)
                report($sformatf("device errors %h, want %h", data[26:11], want.device_errors));
            if (last !== want.frame_last)
                report($sformatf("tlast %b, want %b", last, want.frame_last));
        endtask
    endclass

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [TUSER_W-1:0] m_tuser;
    logic               m_tlast;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    frame_scoreboard sb;
    bit          s_gaps     = 1'b1;
    bit          m_gaps     = 1'b1;
    int unsigned sent_items = 0;

    response_frame_deframer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= !(m_gaps && $urandom_range(99) < 32);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (s_gaps && $urandom_range(99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        void'(sb.take_byte(b));
        sent_items++;
    endtask

    // header, then payload and crc when the length allows; only the first keep bytes go out
    task automatic put_frame(input logic [7:0] ver, input logic [15:0] len,
                             input logic [7:0] id, input logic [7:0] fc,
                             input logic [15:0] derr, input int keep);
        logic [7:0] fb[$];
        fb.insert(fb.size(), SYNC_BYTE);
        fb.insert(fb.size(), ver);
        fb.insert(fb.size(), len[7:0]);
        fb.insert(fb.size(), len[15:8]);
        fb.insert(fb.size(), id);
        fb.insert(fb.size(), fc);
        fb.insert(fb.size(), derr[7:0]);
        fb.insert(fb.size(), derr[15:8]);
        if (len >= MIN_LENGTH) begin
            for (int i = 0; i < int'(len) - 2; i++) fb.insert(fb.size(), 8'($urandom_range(255)));
        end
        for (int i = 0; i < fb.size() && i < keep; i++) send_byte(fb[i]);
    endtask

    // mostly well-formed frames, the rest broken headers, cut frames and line noise
    task automatic random_frame(input bit big);
        int          pick;
        int          keep;
        logic [7:0]  ver;
        logic [7:0]  id;
        logic [7:0]  fc;
        logic [15:0] len;
        logic [15:0] derr;
        pick = $urandom_range(99);
        keep = 1 << 20;
        ver  = SYNC_BYTE;
        id   = sb.want_id;
        fc   = sb.want_fc;
        derr = '0;
        if (big) len = 16'($urandom_range(256, 300));
        else if ($urandom_range(9) == 0) len = 16'($urandom_range(13, 60));
        else len = 16'($urandom_range(5, 12));
        if (pick >= 95) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            return;
        end
        if (pick >= 68) begin
            if (pick < 72) begin
                ver = 8'($urandom_range(254));
            end else if (pick < 75) begin
                len = '0;
            end else if (pick < 79) begin
                len = 16'($urandom_range(1, 4));
            end else if (pick < 86) begin
                // id or code wrong, sometimes with device errors as well
                if (pick < 83) id = id ^ 8'($urandom_range(1, 255));
                else fc = fc ^ 8'($urandom_range(1, 255));
                if ($urandom_range(1)) derr = 16'($urandom_range(1, 65535));
            end else if (pick < 90) begin
                derr = 16'($urandom_range(1, 65535));
                if ($urandom_range(1)) len = 16'($urandom_range(1, 4));
            end else begin
                keep = $urandom_range(1, 12);
            end
        end
        put_frame(ver, len, id, fc, derr, keep);
    endtask

    // apb write: setup then access
    task automatic cfg_write(input logic sel, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(sel, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender until every predicted beat has come, then let the parser settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // run-time limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // main sequence
    initial begin
        int unsigned goal;
        bit          paused;
        bit          big_done;
        logic [7:0]  id_val;
        logic [7:0]  fc_val;
        sb       = new();
        paused   = 1'b0;
        big_done = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: dropped noise, version, zero-len, short, mismatch over device, a good frame
        send_byte(8'h00);
        send_byte(8'h7E);
        put_frame(8'h00, 16'd5, 8'h00, 8'h00, 16'h0000, 2);
        put_frame(SYNC_BYTE, 16'd0, 8'h00, 8'h00, 16'h0000, 4);
        put_frame(SYNC_BYTE, 16'd4, 8'h00, 8'h00, 16'h0000, 8);
        put_frame(SYNC_BYTE, 16'd5, 8'h01, 8'h00, 16'hFFFF, 8);
        put_frame(SYNC_BYTE, 16'd5, 8'h00, 8'h00, 16'h0000, 1 << 20);

        // random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: begin
                    id_val = 8'hFF;
                    fc_val = 8'hFF;
                end
                1: begin
                    id_val = 8'h00;
                    fc_val = 8'h00;
                end
                2: begin
                    id_val = 8'hFF;
                    fc_val = 8'h00;
                end
                default: begin
                    id_val = 8'($urandom_range(255));
                    fc_val = 8'($urandom_range(255));
                end
            endcase
            cfg_write(REG_NODE_ID, id_val);
            cfg_write(REG_FN_CODE, fc_val);
            s_gaps = (p != 3);
            m_gaps = (p != 3);
            goal   = sent_items + 235;
            while (sent_items < goal) begin
                random_frame(p == 6 && !big_done);
                if (p == 6) big_done = 1'b1;
                if (p == 5 && !paused && sent_items + 120 >= goal) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rfd_pkg.sv
rtl/rfd_regs.sv
rtl/rfd_parser.sv
rtl/rfd_out_buf.sv
rtl/response_frame_deframer_top.sv
tb/sv/response_frame_deframer_top_tb.sv
